// ===== rtl/core/pstv_pkg.sv =====
package pstv_pkg;

   localparam int MAX_PLANES      = 4;
   localparam int WORDS_PER_PLANE = 6;
   localparam int TABLE_WORDS     = MAX_PLANES * WORDS_PER_PLANE;
   localparam int DATA_W          = 32;
   localparam int DIV_STAGES      = DATA_W;
   localparam int LIMIT_W         = 16;
   localparam int POINT_PLANES    = 2;
   localparam int SHORT_PLANES    = 2;
   localparam int LONG_PLANES     = 4;

   localparam logic [LIMIT_W-1:0] LIMIT_BIAS = 16'd30;

   // word offsets within one plane
   localparam int K_OFFSET = 3;
   localparam int K_REF    = 4;
   localparam int K_LEN    = 5;

   localparam logic [2:0] CMD_POINT32 = 3'd0;
   localparam logic [2:0] CMD_POINT16 = 3'd1;
   localparam logic [2:0] CMD_RADIUS2 = 3'd2;
   localparam logic [2:0] CMD_RADIUS4 = 3'd3;
   localparam logic [2:0] CMD_WRITE   = 3'd4;

   typedef struct packed {
      logic                      is_point;
      logic                      is_radius;
      logic [MAX_PLANES-1:0]     plane_en;
      logic                      point_ok;
      logic [MAX_PLANES-1:0]     side;
      logic [MAX_PLANES-1:0]     bad;
      logic [MAX_PLANES-1:0]     neg;
      logic signed [LIMIT_W-1:0] limit;
   } ctrl_type;

endpackage

// ===== rtl/core/plane_side_visibility_test.sv =====
// Plane side visibility test. Each word accepted on start (busy is always low) gives
// exactly one result word, strobed on rsp_valid. The word passes through one capture stage,
// one multiply stage, one sum stage, one side/sign stage, a 32-stage restoring divider
// (one quotient bit per stage), one compare stage and the output register.
// A new word may be issued every cycle and results cannot be held off.
// Table writes (cmd 4) take effect at once, so a test issued in the very next cycle
// already sees the new plane words; reading a plane word never written is undefined.
module plane_side_visibility_test (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic signed [31:0] req_px,
   input  logic signed [31:0] req_py,
   input  logic signed [31:0] req_pz,
   input  logic [31:0] req_radius,
   input  logic [4:0]  req_word_index,
   input  logic [31:0] req_word_value,
   output logic        rsp_valid,
   output logic        rsp_visible,
   output logic        rsp_div_fault
);
   import pstv_pkg::*;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // plane table, flops, read at fixed places
   logic [DATA_W-1:0] tbl_ff [TABLE_WORDS];

   always_ff @(posedge clock) begin
      if (accept && req_cmd == CMD_WRITE && 32'(req_word_index) < 32'(TABLE_WORDS)) begin
         tbl_ff[req_word_index] <= req_word_value;
      end
   end

   // stage A: capture, 16-bit sign extension, limit
   logic                     a_valid_ff;
   logic [2:0]               a_cmd_ff;
   logic [DATA_W-1:0]        a_pt_ff [3];
   logic [LIMIT_W-1:0]       a_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      a_cmd_ff <= req_cmd;
      if (req_cmd == CMD_POINT16) begin
         a_pt_ff[0] <= {{16{req_px[15]}}, req_px[15:0]};
         a_pt_ff[1] <= {{16{req_py[15]}}, req_py[15:0]};
         a_pt_ff[2] <= {{16{req_pz[15]}}, req_pz[15:0]};
      end else begin
         a_pt_ff[0] <= req_px;
         a_pt_ff[1] <= req_py;
         a_pt_ff[2] <= req_pz;
      end
      // int16 of radius*8+30
      a_lim_ff <= {req_radius[LIMIT_W-4:0], 3'b000} + LIMIT_BIAS;
   end

   // stage B: products, wrapped to 32 bits
   logic               b_valid_ff;
   logic [2:0]         b_cmd_ff;
   logic [LIMIT_W-1:0] b_lim_ff;
   logic [DATA_W-1:0]  b_prod_ff [MAX_PLANES][3];
   logic [DATA_W-1:0]  b_off_ff  [MAX_PLANES];
   logic [DATA_W-1:0]  b_ref_ff  [MAX_PLANES];
   logic [DATA_W-1:0]  b_len_ff  [MAX_PLANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_cmd_ff <= a_cmd_ff;
      b_lim_ff <= a_lim_ff;
      for (int p = 0; p < MAX_PLANES; p++) begin
         for (int k = 0; k < 3; k++) begin
            b_prod_ff[p][k] <= tbl_ff[p*WORDS_PER_PLANE+k] * a_pt_ff[k];
         end
         b_off_ff[p] <= tbl_ff[p*WORDS_PER_PLANE+K_OFFSET];
         b_ref_ff[p] <= tbl_ff[p*WORDS_PER_PLANE+K_REF];
         b_len_ff[p] <= tbl_ff[p*WORDS_PER_PLANE+K_LEN];
      end
   end

   // stage C: plane values
   logic               c_valid_ff;
   logic [2:0]         c_cmd_ff;
   logic [LIMIT_W-1:0] c_lim_ff;
   logic [DATA_W-1:0]  c_val_ff [MAX_PLANES];
   logic [DATA_W-1:0]  c_ref_ff [MAX_PLANES];
   logic [DATA_W-1:0]  c_len_ff [MAX_PLANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_cmd_ff <= b_cmd_ff;
      c_lim_ff <= b_lim_ff;
      for (int p = 0; p < MAX_PLANES; p++) begin
         c_val_ff[p] <= b_off_ff[p] + b_prod_ff[p][0] + b_prod_ff[p][1] + b_prod_ff[p][2];
         c_ref_ff[p] <= b_ref_ff[p];
         c_len_ff[p] <= b_len_ff[p];
      end
   end

   // stage D: side tests, divider operands as magnitudes
   ctrl_type          d_ctrl_in;
   ctrl_type          d_ctrl_ff;
   logic              d_valid_ff;
   logic [DATA_W-1:0] d_num_in [MAX_PLANES];
   logic [DATA_W-1:0] d_den_in [MAX_PLANES];
   logic [DATA_W-1:0] d_num_ff [MAX_PLANES];
   logic [DATA_W-1:0] d_den_ff [MAX_PLANES];

   always_comb begin
      logic              v_pos;
      logic              v_neg;
      logic              r_pos;
      logic              r_neg;
      logic [DATA_W-1:0] num;
      logic [DATA_W-1:0] den;
      d_ctrl_in           = '0;
      d_ctrl_in.is_point  = (c_cmd_ff == CMD_POINT32) || (c_cmd_ff == CMD_POINT16);
      d_ctrl_in.is_radius = (c_cmd_ff == CMD_RADIUS2) || (c_cmd_ff == CMD_RADIUS4);
      d_ctrl_in.limit     = c_lim_ff;
      d_ctrl_in.point_ok  = 1'b1;
      for (int p = 0; p < MAX_PLANES; p++) begin
         v_pos = !c_val_ff[p][DATA_W-1] && (c_val_ff[p] != '0);
         v_neg = c_val_ff[p][DATA_W-1];
         r_pos = !c_ref_ff[p][DATA_W-1] && (c_ref_ff[p] != '0);
         r_neg = c_ref_ff[p][DATA_W-1];
         if (p < POINT_PLANES && !((v_pos && r_pos) || (v_neg && r_neg))) begin
            d_ctrl_in.point_ok = 1'b0;
         end
         d_ctrl_in.plane_en[p] = ((c_cmd_ff == CMD_RADIUS2) && (p < SHORT_PLANES)) ||
                                 ((c_cmd_ff == CMD_RADIUS4) && (p < LONG_PLANES));
         d_ctrl_in.side[p] = (r_pos && !v_neg) || (r_neg && !v_pos);
         // wrapped |value|: the most negative value stays negative
         num = v_neg ? (DATA_W'(0) - c_val_ff[p]) : c_val_ff[p];
         den = c_len_ff[p];
         d_ctrl_in.bad[p] = (den == '0) ||
                            ((num == {1'b1, {(DATA_W-1){1'b0}}}) && (den == '1));
         d_ctrl_in.neg[p] = num[DATA_W-1] ^ den[DATA_W-1];
         d_num_in[p] = num[DATA_W-1] ? (DATA_W'(0) - num) : num;
         d_den_in[p] = den[DATA_W-1] ? (DATA_W'(0) - den) : den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
      d_ctrl_ff <= d_ctrl_in;
      for (int p = 0; p < MAX_PLANES; p++) begin
         d_num_ff[p] <= d_num_in[p];
         d_den_ff[p] <= d_den_in[p];
      end
   end

   // divider lanes, control words travel alongside
   logic [DATA_W-1:0] quo [MAX_PLANES];

   for (genvar p = 0; p < MAX_PLANES; p++) begin : g_lane
      pstv_div u_div (
         .clock    (clock),
         .dividend (d_num_ff[p]),
         .divisor  (d_den_ff[p]),
         .quotient (quo[p])
      );
   end

   logic     q_valid_ff [DIV_STAGES];
   ctrl_type q_ctrl_ff  [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            q_valid_ff[s] <= 1'b0;
         end
      end else begin
         q_valid_ff[0] <= d_valid_ff;
         for (int s = 1; s < DIV_STAGES; s++) begin
            q_valid_ff[s] <= q_valid_ff[s-1];
         end
      end
      q_ctrl_ff[0] <= d_ctrl_ff;
      for (int s = 1; s < DIV_STAGES; s++) begin
         q_ctrl_ff[s] <= q_ctrl_ff[s-1];
      end
   end

   // stage E: signed quotient against the limit
   logic                  e_valid_ff;
   ctrl_type              e_ctrl_ff;
   logic [MAX_PLANES-1:0] e_below_ff;
   logic [MAX_PLANES-1:0] e_below_in;

   always_comb begin
      logic signed [DATA_W:0] q_s;
      logic signed [DATA_W:0] lim_s;
      lim_s = (DATA_W+1)'(q_ctrl_ff[DIV_STAGES-1].limit);
      for (int p = 0; p < MAX_PLANES; p++) begin
         q_s = q_ctrl_ff[DIV_STAGES-1].neg[p] ? -$signed({1'b0, quo[p]})
                                               :  $signed({1'b0, quo[p]});
         e_below_in[p] = q_s < lim_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= q_valid_ff[DIV_STAGES-1];
      end
      e_ctrl_ff  <= q_ctrl_ff[DIV_STAGES-1];
      e_below_ff <= e_below_in;
   end

   // stage F: planes in order, first bad division ends the test
   logic f_vis_in;
   logic f_fault_in;

   always_comb begin
      logic stop;
      logic vis;
      stop       = 1'b0;
      vis        = 1'b1;
      f_fault_in = 1'b0;
      for (int p = 0; p < MAX_PLANES; p++) begin
         if (e_ctrl_ff.plane_en[p] && !stop && !e_ctrl_ff.side[p]) begin
            if (e_ctrl_ff.bad[p]) begin
               f_fault_in = 1'b1;
               stop       = 1'b1;
            end else if (!e_below_ff[p]) begin
               vis = 1'b0;
            end
         end
      end
      if (e_ctrl_ff.is_point) begin
         f_vis_in   = e_ctrl_ff.point_ok;
         f_fault_in = 1'b0;
      end else if (e_ctrl_ff.is_radius) begin
         f_vis_in = vis && !f_fault_in;
      end else begin
         f_vis_in   = 1'b0;
         f_fault_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= e_valid_ff;
      end
      rsp_visible   <= f_vis_in;
      rsp_div_fault <= f_fault_in;
   end

endmodule

// ===== rtl/core/pstv_div.sv =====
module pstv_div (
   input  logic                    clock,
   input  logic [pstv_pkg::DATA_W-1:0] dividend,
   input  logic [pstv_pkg::DATA_W-1:0] divisor,
   output logic [pstv_pkg::DATA_W-1:0] quotient
);
   import pstv_pkg::*;

   // restoring divider, one quotient bit per stage
   logic [DATA_W-1:0] rem_ff [DIV_STAGES];
   logic [DATA_W-1:0] quo_ff [DIV_STAGES];
   logic [DATA_W-1:0] dsr_ff [DIV_STAGES];
   logic [DATA_W-1:0] rem_in [DIV_STAGES];
   logic [DATA_W-1:0] quo_in [DIV_STAGES];
   logic [DATA_W-1:0] dsr_in [DIV_STAGES];

   always_comb begin
      logic [DATA_W-1:0] rem_src;
      logic [DATA_W-1:0] quo_src;
      logic [DATA_W-1:0] dsr_src;
      logic [DATA_W:0]   trial;
      logic [DATA_W:0]   diff;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            rem_src = '0;
            quo_src = dividend;
            dsr_src = divisor;
         end else begin
            rem_src = rem_ff[s-1];
            quo_src = quo_ff[s-1];
            dsr_src = dsr_ff[s-1];
         end
         trial = {rem_src, quo_src[DATA_W-1]};
         diff  = trial - {1'b0, dsr_src};
         if (!diff[DATA_W]) begin
            rem_in[s] = diff[DATA_W-1:0];
            quo_in[s] = {quo_src[DATA_W-2:0], 1'b1};
         end else begin
            rem_in[s] = trial[DATA_W-1:0];
            quo_in[s] = {quo_src[DATA_W-2:0], 1'b0};
         end
         dsr_in[s] = dsr_src;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         rem_ff[s] <= rem_in[s];
         quo_ff[s] <= quo_in[s];
         dsr_ff[s] <= dsr_in[s];
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule
